FILE: hdl/mc2d_pkg.sv
`timescale 1ns / 1ps

package mc2d_pkg;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int TAP_W      = 3;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 8;
  localparam int PIX_W      = 8;
  localparam int VAL_W      = 28;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int KSIZE_W    = 3;
  localparam int DIM_W      = 9;

  // Signed width for index folding; covers image sides up to 4096
  localparam int IDX_W      = 16;
  localparam logic signed [IDX_W-1:0] IDX_ONE = 1;

  // Coefficient times unsigned pixel
  localparam int PROD_W     = COEF_W + PIX_W + 1;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // Word kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KSIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

  localparam logic [KSIZE_W-1:0] KSIZE_RST = 3'd3;
  localparam logic [DIM_W-1:0]   DIM_RST   = 9'd256;

endpackage

FILE: hdl/mc2d_in_if.sv
`timescale 1ns / 1ps

interface mc2d_in_if import mc2d_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TAP_W-1:0]    tap_row;
  logic [TAP_W-1:0]    tap_col;
  logic signed [COEF_W-1:0] coef_value;
  logic [POS_W-1:0]    pixel_row;
  logic [POS_W-1:0]    pixel_col;
  logic [PIX_W-1:0]    pixel_value;

  modport source (
    output valid, kind, tap_row, tap_col, coef_value, pixel_row, pixel_col, pixel_value,
    input  ready
  );
  modport sink (
    input  valid, kind, tap_row, tap_col, coef_value, pixel_row, pixel_col, pixel_value,
    output ready
  );
endinterface

FILE: hdl/mc2d_out_if.sv
`timescale 1ns / 1ps

interface mc2d_out_if import mc2d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] filtered_value;
  logic             out_of_range;

  modport source (
    output valid, filtered_value, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, filtered_value, out_of_range,
    output ready
  );
endinterface

FILE: hdl/mirrored_2d_convolution_abs.sv
`timescale 1ns / 1ps
// Coefficient load and pixel write words are taken on acceptance and give no result.
// An in-range read walks the K*K taps (K = kernel side in use): one
// multiply-accumulate per cycle through the single image read port, then a pipeline drain.
// An out-of-range read skips the taps and goes straight to the done state.
// Reset (rst_ni, asynchronous, active low) clears control state and the configuration
// registers; image and kernel stores keep their contents and need no clearing pass.

module mirrored_2d_convolution_abs import mc2d_pkg::*; #(
  parameter int MAX_TAPS = 5,
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mc2d_in_if.sink               in_i,
  mc2d_out_if.source            out_o
);

  localparam int TW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int KEW   = $clog2(MAX_TAPS + 1);
  localparam int KAW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS * MAX_TAPS) : 1;
  localparam int KDEP  = MAX_TAPS * MAX_TAPS;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
  localparam int IDEP  = MAX_ROWS * MAX_COLS;
  localparam int SUM_W = PROD_W + $clog2(MAX_TAPS * MAX_TAPS);
  localparam int ACC_W = (SUM_W > VAL_W + 1) ? SUM_W : VAL_W + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Half-sample mirror once, then clamp to the nearest edge
  function automatic logic signed [IDX_W-1:0] fold_idx(input logic signed [IDX_W-1:0] idx,
                                                        input logic signed [IDX_W-1:0] n);
    logic signed [IDX_W-1:0] i;
    i = idx;
    if (i[IDX_W-1]) i = ~i;
    if (i >= n) i = (n <<< 1) - i - IDX_ONE;
    if (i[IDX_W-1]) i = '0;
    if (i >= n) i = n - IDX_ONE;
    return i;
  endfunction

  // Configuration
  logic [KSIZE_W-1:0] ksize_q;
  logic [DIM_W-1:0]   rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q <= KSIZE_RST;
      rows_q  <= DIM_RST;
      cols_q  <= DIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KSIZE: ksize_q <= cfg_data_i[KSIZE_W-1:0];
        CFG_ROWS:  rows_q  <= cfg_data_i[DIM_W-1:0];
        CFG_COLS:  cols_q  <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [IDX_W-1:0] rows_eff, cols_eff;
  logic [KEW-1:0]          k_eff;

  assign rows_eff = (IDX_W'(rows_q) > IDX_W'(MAX_ROWS)) ? IDX_W'(MAX_ROWS) : IDX_W'(rows_q);
  assign cols_eff = (IDX_W'(cols_q) > IDX_W'(MAX_COLS)) ? IDX_W'(MAX_COLS) : IDX_W'(cols_q);
  assign k_eff    = (ksize_q == '0) ? KEW'(1) :
                    (32'(ksize_q) > MAX_TAPS) ? KEW'(MAX_TAPS) : KEW'(ksize_q);

  // Sequencer and pipeline registers
  logic [1:0]              state_q, state_d;
  logic [TW-1:0]           x_q, x_d, y_q, y_d;
  logic [KEW-1:0]          k_q, k_d;
  logic [POS_W-1:0]        prow_q, prow_d, pcol_q, pcol_d;
  logic                    s1_v_q, s1_v_d, s2_v_q, s3_v_q;
  logic [RW-1:0]           ri_q, ri_d;
  logic [CW-1:0]           ci_q, ci_d;
  logic [KAW-1:0]          ka_q, ka_d;
  logic [PIX_W-1:0]        pix_rd_q;
  logic signed [COEF_W-1:0] coef_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    res_oor_q, res_oor_d;
  logic                    out_valid_q, out_valid_d;
  logic [VAL_W-1:0]        out_val_q, out_val_d;
  logic                    out_oor_q, out_oor_d;

  logic                    accept;
  logic                    in_rng;
  logic                    ker_we, img_we;
  logic signed [IDX_W-1:0] half, ri_raw, ci_raw, ri_f, ci_f;
  logic                    y_last, x_last;
  logic [ACC_W-1:0]        mag;
  logic [VAL_W-1:0]        sat;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign in_rng = ($signed(IDX_W'(in_i.pixel_row)) < rows_eff) &&
                  ($signed(IDX_W'(in_i.pixel_col)) < cols_eff);

  assign ker_we = accept && (in_i.kind == KIND_LOAD) &&
                  (32'(in_i.tap_row) < MAX_TAPS) && (32'(in_i.tap_col) < MAX_TAPS);
  assign img_we = accept && (in_i.kind == KIND_WRITE) && in_rng;

  assign half   = IDX_W'(k_q >> 1);
  assign ri_raw = $signed(IDX_W'(prow_q)) - $signed(IDX_W'(x_q)) + half;
  assign ci_raw = $signed(IDX_W'(pcol_q)) - $signed(IDX_W'(y_q)) + half;
  assign ri_f   = fold_idx(ri_raw, rows_eff);
  assign ci_f   = fold_idx(ci_raw, cols_eff);
  assign y_last = (KEW'(y_q) == k_q - KEW'(1));
  assign x_last = (KEW'(x_q) == k_q - KEW'(1));

  assign mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign sat = (mag > ACC_W'(VAL_MAX)) ? VAL_MAX : mag[VAL_W-1:0];

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    k_d         = k_q;
    prow_d      = prow_q;
    pcol_d      = pcol_q;
    s1_v_d      = 1'b0;
    ri_d        = ri_q;
    ci_d        = ci_q;
    ka_d        = ka_q;
    acc_d       = acc_q;
    res_oor_d   = res_oor_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_val_d   = out_val_q;
    out_oor_d   = out_oor_q;

    if (s3_v_q) acc_d = acc_q + ACC_W'(prod_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.kind == KIND_READ)) begin
          acc_d     = '0;
          res_oor_d = !in_rng;
          prow_d    = in_i.pixel_row;
          pcol_d    = in_i.pixel_col;
          k_d       = k_eff;
          x_d       = '0;
          y_d       = '0;
          state_d   = in_rng ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        // issue one tap per cycle
        s1_v_d = 1'b1;
        ri_d   = ri_f[RW-1:0];
        ci_d   = ci_f[CW-1:0];
        ka_d   = KAW'(KAW'(x_q) * KAW'(MAX_TAPS) + KAW'(y_q));
        if (y_last) begin
          y_d = '0;
          x_d = x_q + TW'(1);
          if (x_last) state_d = ST_DRAIN;
        end else begin
          y_d = y_q + TW'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q && !s3_v_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_oor_q ? '0 : sat;
          out_oor_d   = res_oor_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      k_q         <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      res_oor_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      k_q         <= k_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      res_oor_q   <= res_oor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prow_q    <= prow_d;
    pcol_q    <= pcol_d;
    ri_q      <= ri_d;
    ci_q      <= ci_d;
    ka_q      <= ka_d;
    acc_q     <= acc_d;
    out_val_q <= out_val_d;
    out_oor_q <= out_oor_d;
    prod_q    <= coef_rd_q * $signed({1'b0, pix_rd_q});
  end

  // Stores: one write port each, one registered read port
  logic [PIX_W-1:0]         img_mem [IDEP];
  logic signed [COEF_W-1:0] ker_mem [KDEP];

  always_ff @(posedge clk_i) begin
    if (img_we) begin
      img_mem[AW'(AW'(in_i.pixel_row) * AW'(MAX_COLS) + AW'(in_i.pixel_col))] <=
        in_i.pixel_value;
    end
    pix_rd_q <= img_mem[AW'(AW'(ri_q) * AW'(MAX_COLS) + AW'(ci_q))];
  end

  always_ff @(posedge clk_i) begin
    if (ker_we) begin
      ker_mem[KAW'(KAW'(in_i.tap_row) * KAW'(MAX_TAPS) + KAW'(in_i.tap_col))] <=
        in_i.coef_value;
    end
    coef_rd_q <= ker_mem[ka_q];
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_value = out_val_q;
  assign out_o.out_of_range   = out_oor_q;

`ifndef SYNTHESIS
  a_acc_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("accumulate outside a read");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result word not produced by sequencer");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_oor_q) |-> (out_val_q == '0))
    else $error("out-of-range result carries a value");

  a_drain_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && $past(state_q) == ST_DRAIN) |-> !s1_v_q)
    else $error("tap issued during drain");

  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.kind == KIND_READ && in_rng) |=> (state_q == ST_RUN))
    else $error("in-range read did not start the sequencer");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top import mc2d_pkg::*; ();

  localparam int TAPS          = 5;
  localparam int ROWS_MAX      = 256;
  localparam int COLS_MAX      = 256;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 150;
  localparam int PHASES        = 10;

  localparam logic [KIND_W-1:0]    KIND_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7FFF;

  // Kernel side, rows and columns written for each phase
  localparam int PHASE_KSIZE [PHASES] = '{5, 1, 0, 7, 5, 2, 4, 5, 6, 3};
  localparam int PHASE_ROWS  [PHASES] = '{256, 2, 7, 16, 1, 3, 256, 0, 200, 256};
  localparam int PHASE_COLS  [PHASES] = '{256, 2, 300, 9, 5, 511, 2, 40, 256, 256};

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [TAP_W-1:0]         tap_row;
    logic [TAP_W-1:0]         tap_col;
    logic signed [COEF_W-1:0] coef_value;
    logic [POS_W-1:0]         pixel_row;
    logic [POS_W-1:0]         pixel_col;
    logic [PIX_W-1:0]         pixel_value;
  } conv_word_t;

  typedef struct {
    int               row;
    int               col;
    logic [VAL_W-1:0] value;
    logic             off_image;
  } filter_result_t;

  class conv_scoreboard;
    logic [PIX_W-1:0]         pix_mem  [ROWS_MAX*COLS_MAX];
    bit                       pix_set  [ROWS_MAX*COLS_MAX];
    logic signed [COEF_W-1:0] coef_mem [TAPS*TAPS];
    bit                       coef_set [TAPS*TAPS];
    logic [KSIZE_W-1:0]       ksize;
    logic [DIM_W-1:0]         n_rows;
    logic [DIM_W-1:0]         n_cols;
    filter_result_t           awaited [$];
    int failures, checked, loads, writes, reads, off_reads, ignored;

    function new();
      ksize  = KSIZE_RST;
      n_rows = DIM_RST;
      n_cols = DIM_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_KSIZE: ksize = data[KSIZE_W-1:0];
        CFG_ROWS:  n_rows = data[DIM_W-1:0];
        CFG_COLS:  n_cols = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int rows_in_use();
      return (n_rows > ROWS_MAX) ? ROWS_MAX : int'(n_rows);
    endfunction

    function int cols_in_use();
      return (n_cols > COLS_MAX) ? COLS_MAX : int'(n_cols);
    endfunction

    function int taps_in_use();
      if (ksize == 0) return 1;
      return (ksize > TAPS) ? TAPS : int'(ksize);
    endfunction

    // Mirror once about the half-sample edge, then clamp what is still outside
    function int fold(int idx, int n);
      if (idx < 0) idx = -idx - 1;
      if (idx >= n) idx = 2 * n - idx - 1;
      if (idx < 0) idx = 0;
      if (idx >= n) idx = n - 1;
      return idx;
    endfunction

    // Sum over the kernel window; the flag tells whether every entry touched was written
    function bit sweep(int r, int c, output longint sum);
      int  k, half, ri, ci;
      bit  ok;
      k    = taps_in_use();
      half = k / 2;
      sum  = 0;
      ok   = 1'b1;
      for (int x = 0; x < k; x++) begin
        ri = fold(r - x + half, rows_in_use());
        for (int y = 0; y < k; y++) begin
          ci = fold(c - y + half, cols_in_use());
          ok = ok && pix_set[ri*COLS_MAX+ci] && coef_set[x*TAPS+y];
          sum += longint'(coef_mem[x*TAPS+y]) * longint'({1'b0, pix_mem[ri*COLS_MAX+ci]});
        end
      end
      return ok;
    endfunction

    function bit read_ok(int r, int c);
      longint sum;
      if (r >= rows_in_use() || c >= cols_in_use()) return 1'b1;
      return sweep(r, c, sum);
    endfunction

    function void note_word(conv_word_t wd);
      filter_result_t res;
      longint         sum;
      int             r, c;
      r = wd.pixel_row;
      c = wd.pixel_col;
      case (wd.kind)
        KIND_LOAD: begin
          if (wd.tap_row < TAPS && wd.tap_col < TAPS) begin
            coef_mem[wd.tap_row*TAPS+wd.tap_col] = wd.coef_value;
            coef_set[wd.tap_row*TAPS+wd.tap_col] = 1'b1;
            loads++;
          end else begin
            ignored++;
          end
        end
        KIND_WRITE: begin
          if (r < rows_in_use() && c < cols_in_use()) begin
            pix_mem[r*COLS_MAX+c] = wd.pixel_value;
            pix_set[r*COLS_MAX+c] = 1'b1;
            writes++;
          end else begin
            ignored++;
          end
        end
        KIND_READ: begin
          res.row = r;
          res.col = c;
          if (r >= rows_in_use() || c >= cols_in_use()) begin
            res.value     = '0;
            res.off_image = 1'b1;
            off_reads++;
          end else begin
            void'(sweep(r, c, sum));
            if (sum < 0) sum = -sum;
            if (sum > longint'(VAL_MAX)) sum = longint'(VAL_MAX);
            res.value     = sum[VAL_W-1:0];
            res.off_image = 1'b0;
          end
          reads++;
          awaited.push_back(res);
        end
        default: ignored++;
      endcase
    endfunction

    function void check_result(logic [VAL_W-1:0] value, logic off_image);
      filter_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: value %0d out_of_range %0b", value, off_image);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (value !== want.value || off_image !== want.off_image) begin
        failures++;
        if (failures <= 10)
          $display("read (%0d,%0d): expected value %0d out_of_range %0b, got %0d %0b",
                   want.row, want.col, want.value, want.off_image, value, off_image);
      end
    endfunction
  endclass

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int                    cycle_count = 0;
  int                    settings    = 0;
  bit                    calm_in     = 1'b0;
  bit                    calm_out    = 1'b0;
  conv_scoreboard        sb = new();

  mc2d_in_if  in_if ();
  mc2d_out_if out_if ();

  mirrored_2d_convolution_abs u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial forever #2 clk_i = ~clk_i;

  always_ff @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_top failed");
    $finish;
  end

  function automatic conv_word_t word_of(
    input logic [KIND_W-1:0] kind,
    input logic [TAP_W-1:0] trow, tcol,
    input logic signed [COEF_W-1:0] coef,
    input logic [POS_W-1:0] prow, pcol,
    input logic [PIX_W-1:0] pval
  );
    conv_word_t wd;
    wd.kind        = kind;
    wd.tap_row     = trow;
    wd.tap_col     = tcol;
    wd.coef_value  = coef;
    wd.pixel_row   = prow;
    wd.pixel_col   = pcol;
    wd.pixel_value = pval;
    return wd;
  endfunction

  // Favor the edges so that mirroring is exercised
  function automatic int pick_origin(int span, int size);
    if (span <= size) return 0;
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return span - size;
      default: return $urandom_range(0, span - size);
    endcase
  endfunction

  // Reads only land where every pixel and tap they touch has been written
  function automatic conv_word_t pick_word(int r0, int c0, int h, int w);
    conv_word_t wd;
    int         sel, rows_eff, cols_eff;
    bit         found;
    wd = word_of(KIND_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    rows_eff = sb.rows_in_use();
    cols_eff = sb.cols_in_use();
    sel = $urandom_range(0, 99);
    if (sel < 4) return wd;
    if (sel < 18) begin
      wd.kind = KIND_LOAD;
      if ($urandom_range(0, 7) != 0) begin
        wd.tap_row = $urandom_range(0, TAPS - 1);
        wd.tap_col = $urandom_range(0, TAPS - 1);
      end
      return wd;
    end
    if (sel < 45) begin
      wd.kind = KIND_WRITE;
      if (h > 0 && sel < 40) begin
        wd.pixel_row = r0 + $urandom_range(0, h - 1);
        wd.pixel_col = c0 + $urandom_range(0, w - 1);
      end
      return wd;
    end
    wd.kind = KIND_READ;
    found = 1'b0;
    for (int t = 0; t < 8 && !found; t++) begin
      if (h > 0 && $urandom_range(0, 4) != 0) begin
        wd.pixel_row = r0 + $urandom_range(0, h - 1);
        wd.pixel_col = c0 + $urandom_range(0, w - 1);
      end else begin
        wd.pixel_row = $urandom;
        wd.pixel_col = $urandom;
      end
      found = sb.read_ok(wd.pixel_row, wd.pixel_col);
    end
    if (found) return wd;
    if (rows_eff < ROWS_MAX) wd.pixel_row = $urandom_range(rows_eff, ROWS_MAX - 1);
    else if (cols_eff < COLS_MAX) wd.pixel_col = $urandom_range(cols_eff, COLS_MAX - 1);
    else wd.kind = KIND_WRITE;
    return wd;
  endfunction

  task automatic send_word(input conv_word_t wd);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= wd.kind;
    in_if.tap_row     <= wd.tap_row;
    in_if.tap_col     <= wd.tap_col;
    in_if.coef_value  <= wd.coef_value;
    in_if.pixel_row   <= wd.pixel_row;
    in_if.pixel_col   <= wd.pixel_col;
    in_if.pixel_value <= wd.pixel_value;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(wd);
  endtask

  // Hold the input idle until every read has answered and the block has settled
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input int k, input int nr, input int nc);
    logic [CFG_IDX_W-1:0]  idx  [4];
    logic [CFG_DATA_W-1:0] data [4];
    idx[0]  = CFG_KSIZE;
    data[0] = CFG_DATA_W'({$urandom, KSIZE_W'(k)});
    idx[1]  = CFG_ROWS;
    data[1] = CFG_DATA_W'(nr);
    idx[2]  = CFG_COLS;
    data[2] = CFG_DATA_W'(nc);
    idx[3]  = CFG_SPARE;
    data[3] = CFG_DATA_W'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= data[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], data[i]);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(input int k, input int nr, input int nc, input int count);
    int rows_eff, cols_eff, span, h, w, r0, c0;
    drain();
    write_config(k, nr, nc);
    rows_eff = sb.rows_in_use();
    cols_eff = sb.cols_in_use();
    span = sb.taps_in_use() + 2;
    h  = span + $urandom_range(0, 4);
    h  = (rows_eff < h) ? rows_eff : h;
    w  = span + $urandom_range(0, 4);
    w  = (cols_eff < w) ? cols_eff : w;
    r0 = pick_origin(rows_eff, h);
    c0 = pick_origin(cols_eff, w);
    for (int r = r0; r < r0 + h; r++)
      for (int c = c0; c < c0 + w; c++)
        send_word(word_of(KIND_WRITE, $urandom, $urandom, $urandom, r, c, $urandom));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) calm_in = !calm_in;
      if ($urandom_range(0, 149) == 0) drain();
      send_word(pick_word(r0, c0, h, w));
    end
  endtask

  // Result side: drop ready for a random stall before each word unless calm_out is set
  initial begin
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_result(out_if.filtered_value, out_if.out_of_range);
    end
  end

  initial begin : stimulus
    logic signed [COEF_W-1:0] coef;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_NONE;
    in_if.tap_row     = '0;
    in_if.tap_col     = '0;
    in_if.coef_value  = '0;
    in_if.pixel_row   = '0;
    in_if.pixel_col   = '0;
    in_if.pixel_value = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(KSIZE_RST, DIM_RST, DIM_RST);
    // 3x3 kernel with the coefficient extremes at opposite corners
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        coef = $urandom;
        if (x == 0 && y == 0) coef = COEF_MIN;
        if (x == 2 && y == 2) coef = COEF_MAX;
        send_word(word_of(KIND_LOAD, x, y, coef, $urandom, $urandom, $urandom));
      end
    end
    // taps beyond the kernel store are dropped
    send_word(word_of(KIND_LOAD, 7, 1, COEF_MAX, 0, 0, 0));
    send_word(word_of(KIND_LOAD, 0, 5, COEF_MIN, 0, 0, 0));
    send_word(word_of(KIND_WRITE, 0, 0, 0, 0, 0, 255));
    send_word(word_of(KIND_WRITE, 0, 0, 0, 0, 1, 0));
    send_word(word_of(KIND_WRITE, 0, 0, 0, 1, 0, 128));
    send_word(word_of(KIND_WRITE, 0, 0, 0, 1, 1, 1));
    send_word(word_of(KIND_READ, 0, 0, 0, 0, 0, 0));
    send_word(word_of(KIND_WRITE, 0, 0, 0, 254, 254, 255));
    send_word(word_of(KIND_WRITE, 0, 0, 0, 254, 255, 255));
    send_word(word_of(KIND_WRITE, 0, 0, 0, 255, 254, 255));
    send_word(word_of(KIND_WRITE, 0, 0, 0, 255, 255, 255));
    send_word(word_of(KIND_READ, 0, 0, 0, 255, 255, 0));
    send_word(word_of(KIND_NONE, 3, 3, COEF_MAX, 5, 5, 77));

    // fill the remaining taps so that any kernel side reads written coefficients
    for (int x = 0; x < TAPS; x++)
      for (int y = 0; y < TAPS; y++)
        if (x >= 3 || y >= 3)
          send_word(word_of(KIND_LOAD, x, y, $urandom, $urandom, $urandom, $urandom));

    for (int p = 0; p < PHASES; p++)
      run_phase(PHASE_KSIZE[p], PHASE_ROWS[p], PHASE_COLS[p], PHASE_ITEMS);

    drain();
    $display("Covered %0d coefficient loads, %0d pixel writes, %0d ignored words, %0d reads",
             sb.loads, sb.writes, sb.ignored, sb.reads);
    $display("%0d results checked (%0d outside the image) across %0d register settings",
             sb.checked, sb.off_reads, settings);
    if (sb.failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
